[rtl/swhdu_pkg.sv]
// Shared types and constants for the single-wire half-duplex UART.
// Used by swhdu_core, swhdu_oskid and single_wire_half_duplex_uart; no dependencies.
package swhdu_pkg;

    localparam int DATA_BITS    = 8;
    localparam int TICKS_PER_MS = 1000;
    localparam int BYTE_BITS    = 8;
    localparam int BYTE_IDX_W   = $clog2(BYTE_BITS);
    localparam int BIT_IDX_W    = 4;
    localparam int PERIOD_W     = 16;
    localparam int TICK_W       = PERIOD_W + 1;
    localparam int MS_W         = 16;
    localparam int PRESCALE_W   = $clog2(TICKS_PER_MS + 1);

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_RECV = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_RECV = 2'd2
    } mode_t;

    // PH_LEAD is the leading high level on send and the wait for a start edge on receive.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_STOP  = 3'd3,
        PH_FIN   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TIMEOUT   = 2'd1,
        ST_BAD_START = 2'd2,
        ST_BAD_STOP  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [BYTE_BITS-1:0] tx_byte;
        logic [MS_W-1:0]      wait_ms;
        logic                 line_in;
    } item_t;

    typedef struct packed {
        logic                 line_out;
        logic                 drive_enable;
        logic                 busy_res;
        logic                 done_res;
        status_t              status;
        logic [BYTE_BITS-1:0] rx_byte;
    } result_t;

endpackage

[rtl/swhdu_core.sv]
// Send and receive sequencer of the single-wire UART: one step per accepted tick word.
// Depends on swhdu_pkg.
module swhdu_core
    import swhdu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [PERIOD_W-1:0] cfg_data,
    input  logic                accept,
    input  item_t               item,
    output result_t             res
);

    logic [PERIOD_W-1:0]   bit_period_reg;
    mode_t                 mode_reg, mode_next;
    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [BIT_IDX_W-1:0]  bit_reg, bit_next;
    logic [BYTE_BITS-1:0]  shift_reg, shift_next;
    logic [PRESCALE_W-1:0] pre_reg, pre_next;
    logic [MS_W-1:0]       ms_reg, ms_next;
    logic [MS_W-1:0]       limit_reg, limit_next;

    mode_t                 eff_mode;
    phase_t                eff_phase;
    logic [TICK_W-1:0]     eff_tick;
    logic [BIT_IDX_W-1:0]  eff_bit;
    logic [BYTE_BITS-1:0]  eff_shift;
    logic [PRESCALE_W-1:0] eff_pre;
    logic [MS_W-1:0]       eff_ms;
    logic [MS_W-1:0]       eff_limit;

    logic [PERIOD_W-1:0]   per;
    logic [PERIOD_W-2:0]   half;
    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     tx_len;
    logic                  tx_hit;
    logic                  per_hit;
    logic                  half_hit;
    logic [BIT_IDX_W-1:0]  bit_inc;
    logic                  bit_last;
    logic                  bit_in_byte;
    logic [PRESCALE_W-1:0] pre_inc;
    logic                  timed_out;

    assign per         = (bit_period_reg == '0) ? PERIOD_W'(1) : bit_period_reg;
    assign half        = per[PERIOD_W-1:1];
    assign tick_inc    = eff_tick + TICK_W'(1);
    assign tx_hit      = tick_inc >= tx_len;
    assign per_hit     = tick_inc >= {1'b0, per};
    assign half_hit    = tick_inc >= {2'b00, half};
    assign bit_inc     = eff_bit + BIT_IDX_W'(1);
    assign bit_last    = bit_inc >= BIT_IDX_W'(DATA_BITS);
    assign bit_in_byte = eff_bit < BIT_IDX_W'(BYTE_BITS);
    assign pre_inc     = eff_pre + PRESCALE_W'(1);
    assign timed_out   = eff_ms >= eff_limit;

    always_comb
    begin
        case (eff_phase)
            PH_LEAD: tx_len = TICK_W'(2);
            PH_STOP: tx_len = {per, 1'b0};
            default: tx_len = {1'b0, per};
        endcase
    end

    // A request taken in idle starts its operation on the same tick.
    always_comb
    begin
        eff_mode  = mode_reg;
        eff_phase = phase_reg;
        eff_tick  = tick_reg;
        eff_bit   = bit_reg;
        eff_shift = shift_reg;
        eff_pre   = pre_reg;
        eff_ms    = ms_reg;
        eff_limit = limit_reg;
        if (mode_reg == MODE_IDLE)
        begin
            if (item.operation == OP_SEND)
            begin
                eff_mode  = MODE_SEND;
                eff_phase = PH_LEAD;
                eff_tick  = '0;
                eff_bit   = '0;
                eff_shift = item.tx_byte;
            end
            else if (item.operation == OP_RECV)
            begin
                eff_mode  = MODE_RECV;
                eff_phase = PH_LEAD;
                eff_tick  = '0;
                eff_bit   = '0;
                eff_shift = '0;
                eff_pre   = '0;
                eff_ms    = '0;
                eff_limit = item.wait_ms;
            end
        end
    end

    always_comb
    begin
        mode_next  = eff_mode;
        phase_next = eff_phase;
        tick_next  = eff_tick;
        bit_next   = eff_bit;
        shift_next = eff_shift;
        pre_next   = eff_pre;
        ms_next    = eff_ms;
        limit_next = eff_limit;
        case (eff_mode)
            MODE_SEND:
            begin
                if (eff_phase == PH_FIN)
                begin
                    mode_next  = MODE_IDLE;
                    phase_next = PH_LEAD;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tx_hit)
                    begin
                        tick_next = '0;
                        case (eff_phase)
                            PH_LEAD:  phase_next = PH_START;
                            PH_START:
                            begin
                                phase_next = PH_DATA;
                                bit_next   = '0;
                            end
                            PH_DATA:
                            begin
                                bit_next = bit_inc;
                                if (bit_last)
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                            default:  phase_next = PH_FIN;
                        endcase
                    end
                end
            end
            MODE_RECV:
            begin
                case (eff_phase)
                    PH_LEAD:
                    begin
                        if (!item.line_in)
                        begin
                            tick_next = '0;
                            if (half == '0)
                            begin
                                phase_next = PH_DATA;
                                bit_next   = '0;
                                shift_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_START;
                            end
                        end
                        else if (timed_out)
                        begin
                            mode_next  = MODE_IDLE;
                            phase_next = PH_LEAD;
                        end
                        else
                        begin
                            pre_next = pre_inc;
                            if (pre_inc >= PRESCALE_W'(TICKS_PER_MS))
                            begin
                                pre_next = '0;
                                if (eff_ms != '1)
                                begin
                                    ms_next = eff_ms + MS_W'(1);
                                end
                            end
                        end
                    end
                    PH_START:
                    begin
                        tick_next = tick_inc;
                        if (half_hit)
                        begin
                            tick_next = '0;
                            if (item.line_in)
                            begin
                                mode_next  = MODE_IDLE;
                                phase_next = PH_LEAD;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                bit_next   = '0;
                                shift_next = '0;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        tick_next = tick_inc;
                        if (per_hit)
                        begin
                            tick_next = '0;
                            if (bit_in_byte && item.line_in)
                            begin
                                shift_next[eff_bit[BYTE_IDX_W-1:0]] = 1'b1;
                            end
                            bit_next = bit_inc;
                            if (bit_last)
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                    end
                    default:
                    begin
                        tick_next = tick_inc;
                        if (per_hit)
                        begin
                            tick_next  = '0;
                            mode_next  = MODE_IDLE;
                            phase_next = PH_LEAD;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res          = '0;
        res.busy_res = (mode_next != MODE_IDLE);
        case (eff_mode)
            MODE_SEND:
            begin
                if (eff_phase == PH_FIN)
                begin
                    res.done_res = 1'b1;
                end
                else
                begin
                    res.drive_enable = 1'b1;
                    case (eff_phase)
                        PH_LEAD:  res.line_out = 1'b1;
                        PH_START: res.line_out = 1'b0;
                        PH_DATA:  res.line_out = bit_in_byte & eff_shift[eff_bit[BYTE_IDX_W-1:0]];
                        default:  res.line_out = 1'b1;
                    endcase
                end
            end
            MODE_RECV:
            begin
                case (eff_phase)
                    PH_LEAD:
                    begin
                        if (item.line_in && timed_out)
                        begin
                            res.done_res = 1'b1;
                            res.status   = ST_TIMEOUT;
                        end
                    end
                    PH_START:
                    begin
                        if (half_hit && item.line_in)
                        begin
                            res.done_res = 1'b1;
                            res.status   = ST_BAD_START;
                        end
                    end
                    PH_DATA:
                    begin
                    end
                    default:
                    begin
                        if (per_hit)
                        begin
                            res.done_res = 1'b1;
                            if (item.line_in)
                            begin
                                res.rx_byte = eff_shift;
                            end
                            else
                            begin
                                res.status = ST_BAD_STOP;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
            mode_reg       <= MODE_IDLE;
            phase_reg      <= PH_LEAD;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            pre_reg        <= '0;
            ms_reg         <= '0;
            limit_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                bit_period_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                pre_reg   <= pre_next;
                ms_reg    <= ms_next;
                limit_reg <= limit_next;
            end
        end
    end

    a_no_drive_on_recv: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == MODE_RECV) |-> !res.drive_enable)
        else $error("wire driven during a receive");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> !res.busy_res)
        else $error("finishing word still reports busy");

    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res.status != ST_OK) |-> res.done_res)
        else $error("error status without done");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BIT_IDX_W'(DATA_BITS))
        else $error("bit index beyond data bits");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.done_res) |=> (mode_reg == MODE_IDLE))
        else $error("sequencer not idle after finishing");

endmodule

[rtl/swhdu_oskid.sv]
// Two-deep output register with skid stage for UART result words.
// Depends on swhdu_pkg.
module swhdu_oskid
    import swhdu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

[rtl/single_wire_half_duplex_uart.sv]
// Single-wire half-duplex UART (8 data bits, one start, long stop), top level.
// Depends on swhdu_pkg, swhdu_core and swhdu_oskid.
//
// Each input word is one microsecond tick: it carries the sampled wire level and
// optionally a request to send or receive a byte, and it yields exactly one result
// word with the drive level, drive enable, busy, done, status and received byte.
// One word is taken per clock cycle while s_tready is high; each result is held in
// an output register backed by a skid stage, so s_tready falls only when two result
// words are waiting on the master side. The user must write the bit period through
// the cfg port while no operation is in progress; the block does not enforce this.
module single_wire_half_duplex_uart
    import swhdu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // tx_byte[7:0], wait_ms[23:8], line_in[24]
    input  logic [1:0]          s_tuser,   // operation[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // line_out, drive_enable, busy_res, done_res,
                                           // status[5:4], rx_byte[13:6]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data
);

    item_t   item;
    result_t core_res;
    result_t out_res;
    logic    accept;

    assign item.operation = s_tuser;
    assign item.tx_byte   = s_tdata[7:0];
    assign item.wait_ms   = s_tdata[23:8];
    assign item.line_in   = s_tdata[24];

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    swhdu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .res       (core_res)
    );

    swhdu_oskid u_oskid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {2'b00, out_res.rx_byte, out_res.status, out_res.done_res,
                      out_res.busy_res, out_res.drive_enable, out_res.line_out};

endmodule
